// File: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the RTL files.
// Defining ASSERT_OFF turns every check into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// post holds in the same cycle as pre
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// post holds in the cycle after pre
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: rtl/dsdr_pkg.sv
// dsdr_pkg: types and constants of the display shadow-diff refresh block.
// No dependencies; used by dsdr_front, dsdr_queue, dsdr_back and the top level.
package dsdr_pkg;

  localparam int PAGES_DEFAULT = 8;
  localparam int WIDTH_DEFAULT = 128;
  localparam logic [7:0] FORCE_PERIOD_RESET = 8'd50;
  localparam logic [2:0] PAGE_MASK = 3'h7;
  localparam int JOB_PAGE_W = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FULL  = 2'd1,
    OP_AREA  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [2:0]  page;
    logic [6:0]  column;
    logic [7:0]  pixel_byte;
    logic [5:0]  top_row;
    logic [6:0]  area_height;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  seg_page;
    logic [6:0]  first_col;
    logic [6:0]  last_col;
    logic        forced;
    logic        last_segment;
  } result_t;

  typedef enum logic [1:0] {
    J_WRITE,
    J_REFRESH,
    J_CLEAR
  } job_kind_t;

  typedef struct packed {
    job_kind_t              kind;
    logic [JOB_PAGE_W-1:0]  page_lo;
    logic [JOB_PAGE_W-1:0]  page_hi;
    logic                   forced;
    logic [6:0]             column;
    logic [7:0]             pixel_byte;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FINISH
  } back_state_t;

endpackage

// File: rtl/dsdr_ram.sv
// dsdr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dsdr_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dsdr_front.sv
// dsdr_front: takes commands, holds force_period and the frame count, and turns
// each command into a job for the queue. Depends on dsdr_pkg, assert_macros.svh.
`include "assert_macros.svh"

module dsdr_front #(
  parameter int PAGES = dsdr_pkg::PAGES_DEFAULT,
  parameter int WIDTH = dsdr_pkg::WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dsdr_pkg::cmd_t    cmd,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              q_full,
  output logic              push,
  output dsdr_pkg::job_t    job
);

  localparam logic [dsdr_pkg::JOB_PAGE_W-1:0] LAST_PAGE =
    dsdr_pkg::JOB_PAGE_W'(PAGES - 1);

  logic       accept;
  logic [7:0] force_period;
  logic [7:0] frame_count;
  logic [7:0] frame_count_next;
  logic [7:0] cnt_inc;
  logic       force_now;
  logic [6:0] end_row;
  logic [2:0] area_lo;
  logic [2:0] area_hi;
  logic [dsdr_pkg::JOB_PAGE_W-1:0] area_hi_w;

  assign accept = start && !q_full;
  assign busy   = q_full;

  always_comb begin
    cnt_inc   = frame_count + 8'd1;
    force_now = cnt_inc >= force_period;
    // end row wraps mod 64, so a zero height from row 0 lands on the last band
    end_row   = {1'b0, cmd.top_row} + cmd.area_height - 7'd1;
    area_lo   = cmd.top_row[5:3] & dsdr_pkg::PAGE_MASK;
    area_hi   = end_row[5:3] & dsdr_pkg::PAGE_MASK;
    area_hi_w = {1'b0, area_hi};

    job.kind       = dsdr_pkg::J_WRITE;
    job.page_lo    = {1'b0, cmd.page};
    job.page_hi    = '0;
    job.forced     = 1'b0;
    job.column     = cmd.column;
    job.pixel_byte = cmd.pixel_byte;
    push             = 1'b0;
    frame_count_next = frame_count;

    case (cmd.opcode)
      dsdr_pkg::OP_WRITE: begin
        push = accept && (32'(cmd.page) < PAGES) && (32'(cmd.column) < WIDTH);
      end
      dsdr_pkg::OP_FULL: begin
        job.kind    = dsdr_pkg::J_REFRESH;
        job.page_lo = '0;
        job.page_hi = LAST_PAGE;
        job.forced  = force_now;
        push        = accept;
        if (accept) begin
          frame_count_next = force_now ? 8'd0 : cnt_inc;
        end
      end
      dsdr_pkg::OP_AREA: begin
        job.kind    = dsdr_pkg::J_REFRESH;
        job.page_lo = {1'b0, area_lo};
        job.page_hi = (area_hi_w > LAST_PAGE) ? LAST_PAGE : area_hi_w;
        // wrapped or wholly out-of-range areas produce nothing
        push = accept && (area_hi >= area_lo) && (32'(area_lo) < PAGES);
      end
      dsdr_pkg::OP_CLEAR: begin
        job.kind = dsdr_pkg::J_CLEAR;
        push     = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_period <= dsdr_pkg::FORCE_PERIOD_RESET;
      frame_count  <= 8'd0;
    end else begin
      if (cfg_we) begin
        force_period <= cfg_wdata;
      end
      frame_count <= frame_count_next;
    end
  end

  `ASSERT_NEXT(a_force_clears_count, clk, rst, push && job.kind == dsdr_pkg::J_REFRESH && job.forced, frame_count == 8'd0)

endmodule

// File: rtl/dsdr_queue.sv
// dsdr_queue: short job FIFO between the command front end and the back end.
// Depends on dsdr_pkg.
module dsdr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dsdr_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output dsdr_pkg::job_t  head
);

  localparam int DEPTH = dsdr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  dsdr_pkg::job_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = count == CNTW'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop && !empty) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/dsdr_back.sv
// dsdr_back: executes jobs; owns the display and shadow stores, scans pages a
// column per cycle and reports differing spans. Depends on dsdr_pkg, dsdr_ram.
`include "assert_macros.svh"

module dsdr_back #(
  parameter int PAGES = dsdr_pkg::PAGES_DEFAULT,
  parameter int WIDTH = dsdr_pkg::WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  dsdr_pkg::job_t    head,
  output logic              pop,
  output logic              result_valid,
  output dsdr_pkg::result_t result
);

  localparam int DEPTH = PAGES * WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(WIDTH + 1);
  localparam int CIW   = $clog2(WIDTH);
  localparam int PIW   = (PAGES > 1) ? $clog2(PAGES) : 1;

  dsdr_pkg::back_state_t state;
  dsdr_pkg::back_state_t state_next;

  logic [dsdr_pkg::JOB_PAGE_W-1:0] page;
  logic [dsdr_pkg::JOB_PAGE_W-1:0] last_page;
  logic                            forced;
  logic [AW-1:0]                   addr;
  logic [CW-1:0]                   col;
  logic                            rd_valid;
  logic [CIW-1:0]                  rd_col;
  logic [AW-1:0]                   rd_addr;
  logic                            found;
  logic [CIW-1:0]                  first_d;
  logic [CIW-1:0]                  last_d;
  logic [PAGES-1:0]                page_ok;
  logic                            pend_valid;
  dsdr_pkg::result_t               pend;

  logic              issue;
  logic              page_done;
  logic              differs;
  logic              any_diff;
  logic [CIW-1:0]    first_eff;
  logic [CIW-1:0]    last_eff;
  logic [7:0]        shadow_eff;
  logic              seg_emit;
  dsdr_pkg::result_t seg;
  logic              out_fire;
  dsdr_pkg::result_t out_seg;
  logic              disp_we;
  logic [AW-1:0]     disp_waddr;
  logic [AW-1:0]     page_base;
  logic [7:0]        disp_rdata;
  logic [7:0]        sh_rdata;

  dsdr_ram #(.DW(8), .DEPTH(DEPTH)) u_display (
    .clk   (clk),
    .we    (disp_we),
    .waddr (disp_waddr),
    .wdata (head.pixel_byte),
    .raddr (addr),
    .rdata (disp_rdata)
  );

  // the scan writes each display byte back into the shadow as it passes, which
  // is the page copy when the page differs and a no-op when it does not
  dsdr_ram #(.DW(8), .DEPTH(DEPTH)) u_shadow (
    .clk   (clk),
    .we    (rd_valid),
    .waddr (rd_addr),
    .wdata (disp_rdata),
    .raddr (addr),
    .rdata (sh_rdata)
  );

  always_comb begin
    pop        = (state == dsdr_pkg::B_IDLE) && !empty;
    disp_we    = pop && (head.kind == dsdr_pkg::J_WRITE);
    disp_waddr = AW'(32'(head.page_lo) * WIDTH + 32'(head.column));
    page_base  = AW'(32'(head.page_lo) * WIDTH);

    issue      = (state == dsdr_pkg::B_SCAN) && (col < CW'(WIDTH));
    // a page not copied since reset or clear reads as zero
    shadow_eff = page_ok[page[PIW-1:0]] ? sh_rdata : 8'h00;
    differs    = rd_valid && (disp_rdata != shadow_eff);
    any_diff   = found || differs;
    first_eff  = found ? first_d : rd_col;
    last_eff   = differs ? rd_col : last_d;
    page_done  = rd_valid && (rd_col == CIW'(WIDTH - 1));

    seg.seg_page     = page[2:0];
    seg.forced       = forced;
    seg.last_segment = 1'b0;
    if (forced) begin
      seg.first_col = 7'd0;
      seg.last_col  = 7'(WIDTH - 1);
    end else begin
      seg.first_col = 7'(first_eff);
      seg.last_col  = 7'(last_eff);
    end
    seg_emit = page_done && (forced || any_diff);

    // the held segment leaves when a newer one replaces it, or flagged last
    // once the whole range is done
    out_seg              = pend;
    out_seg.last_segment = (state == dsdr_pkg::B_FINISH);
    out_fire = pend_valid && (seg_emit || (state == dsdr_pkg::B_FINISH));

    state_next = state;
    case (state)
      dsdr_pkg::B_IDLE: begin
        if (pop && head.kind == dsdr_pkg::J_REFRESH) begin
          state_next = dsdr_pkg::B_SCAN;
        end
      end
      dsdr_pkg::B_SCAN: begin
        if (page_done && page == last_page) begin
          state_next = dsdr_pkg::B_FINISH;
        end
      end
      dsdr_pkg::B_FINISH: begin
        state_next = dsdr_pkg::B_IDLE;
      end
      default: begin
        state_next = dsdr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsdr_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid     <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      page_ok      <= '0;
      col          <= '0;
    end else begin
      result_valid <= out_fire;
      rd_valid     <= issue;
      if (out_fire) begin
        result <= out_seg;
      end
      if (issue) begin
        rd_col  <= col[CIW-1:0];
        rd_addr <= addr;
        addr    <= addr + AW'(1);
        col     <= col + CW'(1);
      end
      if (pop) begin
        case (head.kind)
          dsdr_pkg::J_REFRESH: begin
            page      <= head.page_lo;
            last_page <= head.page_hi;
            forced    <= head.forced;
            addr      <= page_base;
            col       <= '0;
            found     <= 1'b0;
          end
          dsdr_pkg::J_CLEAR: begin
            page_ok <= '0;
          end
          default: begin
          end
        endcase
      end
      if (rd_valid && !page_done) begin
        found   <= any_diff;
        first_d <= first_eff;
        last_d  <= last_eff;
      end
      if (page_done) begin
        // pages run consecutively, so addr already points at the next page
        page_ok[page[PIW-1:0]] <= 1'b1;
        found <= 1'b0;
        col   <= '0;
        page  <= page + dsdr_pkg::JOB_PAGE_W'(1);
        if (seg_emit) begin
          pend       <= seg;
          pend_valid <= 1'b1;
        end
      end
      if (state == dsdr_pkg::B_FINISH) begin
        pend_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_idle_no_pending, clk, rst, state == dsdr_pkg::B_IDLE, !pend_valid)
  `ASSERT_ALWAYS(a_col_bound, clk, rst, col <= CW'(WIDTH))
  `ASSERT_IMPLIES(a_read_in_scan, clk, rst, rd_valid, $past(state) == dsdr_pkg::B_SCAN)

endmodule

// File: rtl/display_shadow_diff_refresh.sv
// display_shadow_diff_refresh: top level; front end, job queue and back end.
// Depends on dsdr_pkg, dsdr_front, dsdr_queue, dsdr_back, dsdr_ram.
//
//  channel   signals                   transaction
//  command   start, busy, cmd          start high and busy low at a clock edge
//  result    result_valid, result      result_valid high for one cycle
//  config    cfg_we, cfg_wdata         cfg_we high at a clock edge
//
// A write or clear-shadow is carried out as its job is popped. A refresh
// scans each page in range at one column per cycle through the single read
// port of each store. The queue holds two jobs; busy is high while it is full.
// Reset is synchronous; it zeroes the frame count, loads force_period with 50
// and marks every shadow page as cleared. Results cannot be held off.
module display_shadow_diff_refresh #(
  parameter int PAGES = dsdr_pkg::PAGES_DEFAULT,
  parameter int WIDTH = dsdr_pkg::WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dsdr_pkg::cmd_t    cmd,
  output logic              result_valid,
  output dsdr_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  dsdr_pkg::job_t push_job;
  dsdr_pkg::job_t head;

  dsdr_front #(.PAGES(PAGES), .WIDTH(WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  dsdr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  dsdr_back #(.PAGES(PAGES), .WIDTH(WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// File: tb/sv/display_shadow_diff_refresh_tb.sv
// display_shadow_diff_refresh_tb: self-checking testbench for the shadow-diff refresh block.
// Depends on dsdr_pkg and display_shadow_diff_refresh; predicts the refresh segments itself.
`timescale 1ns / 1ps

module display_shadow_diff_refresh_tb;

  localparam int NPAGES      = 8;
  localparam int NCOLS       = 128;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int DRAIN_CAP   = 20000;
  // up to three refresh jobs may still be in flight (two queued, one scanning)
  localparam int TAIL_CYCLES = 3200;
  localparam int RAND_PHASES = 5;

  // Tracks display and shadow contents and the segments each refresh must produce.
  class refresh_tracker;
    logic [7:0]        pixels [NPAGES][NCOLS];
    logic [7:0]        shadow [NPAGES][NCOLS];
    logic [7:0]        frame_count;
    logic [7:0]        force_period;
    dsdr_pkg::result_t staged[$];
    dsdr_pkg::result_t due_segments[$];
    int                mismatches;

    function new();
      for (int p = 0; p < NPAGES; p++) begin
        for (int c = 0; c < NCOLS; c++) begin
          pixels[p][c] = '0;
          shadow[p][c] = '0;
        end
      end
      frame_count  = '0;
      force_period = dsdr_pkg::FORCE_PERIOD_RESET;
      mismatches   = 0;
    endfunction

    function void stage(int p, int lo, int hi, logic forced);
      dsdr_pkg::result_t seg;
      seg.seg_page     = p[2:0];
      seg.first_col    = lo[6:0];
      seg.last_col     = hi[6:0];
      seg.forced       = forced;
      seg.last_segment = 1'b0;
      staged.push_back(seg);
      for (int c = 0; c < NCOLS; c++) shadow[p][c] = pixels[p][c];
    endfunction

    function void diff_page(int p);
      int lo = 0;
      int hi = NCOLS - 1;
      while (lo < NCOLS && shadow[p][lo] == pixels[p][lo]) lo++;
      if (lo == NCOLS) return;
      while (hi > lo && shadow[p][hi] == pixels[p][hi]) hi--;
      stage(p, lo, hi, 1'b0);
    endfunction

    function void take_command(dsdr_pkg::cmd_t c);
      int first_page;
      int last_page;
      case (c.opcode)
        dsdr_pkg::OP_WRITE: begin
          pixels[c.page][c.column] = c.pixel_byte;
        end
        dsdr_pkg::OP_CLEAR: begin
          for (int p = 0; p < NPAGES; p++)
            for (int k = 0; k < NCOLS; k++) shadow[p][k] = '0;
        end
        dsdr_pkg::OP_FULL: begin
          frame_count = frame_count + 8'd1;
          if (frame_count >= force_period) begin
            for (int p = 0; p < NPAGES; p++) stage(p, 0, NCOLS - 1, 1'b1);
            frame_count = '0;
          end else begin
            for (int p = 0; p < NPAGES; p++) diff_page(p);
          end
        end
        dsdr_pkg::OP_AREA: begin
          first_page = int'(c.top_row) / 8;
          // end row taken mod 64, so zero height from row 0 covers the whole panel
          last_page  = ((int'(c.top_row) + int'(c.area_height) + 63) % 64) / 8;
          for (int p = first_page; p <= last_page; p++) diff_page(p);
        end
        default: begin
        end
      endcase
      if (staged.size() > 0) staged[staged.size() - 1].last_segment = 1'b1;
      foreach (staged[i]) due_segments.push_back(staged[i]);
      staged.delete();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task match_segment(dsdr_pkg::result_t got);
      dsdr_pkg::result_t want;
      if (due_segments.size() == 0) begin
        report_mismatch($sformatf("unexpected segment page %0d cols %0d..%0d",
                                  got.seg_page, got.first_col, got.last_col));
        return;
      end
      want = due_segments.pop_front();
      if (got.seg_page !== want.seg_page)
        report_mismatch($sformatf("seg_page %0d, want %0d", got.seg_page, want.seg_page));
      if (got.first_col !== want.first_col)
        report_mismatch($sformatf("first_col %0d, want %0d (page %0d)",
                                  got.first_col, want.first_col, want.seg_page));
      if (got.last_col !== want.last_col)
        report_mismatch($sformatf("last_col %0d, want %0d (page %0d)",
                                  got.last_col, want.last_col, want.seg_page));
      if (got.forced !== want.forced)
        report_mismatch($sformatf("forced %0b, want %0b (page %0d)",
                                  got.forced, want.forced, want.seg_page));
      if (got.last_segment !== want.last_segment)
        report_mismatch($sformatf("last_segment %0b, want %0b (page %0d)",
                                  got.last_segment, want.last_segment, want.seg_page));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  dsdr_pkg::cmd_t    cmd;
  logic              result_valid;
  dsdr_pkg::result_t result;
  logic              cfg_we;
  logic [7:0]        cfg_wdata;

  refresh_tracker tracker;
  int unsigned    cycle_count;

  display_shadow_diff_refresh i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) tracker.match_segment(result);
  end

  function automatic dsdr_pkg::cmd_t make_cmd(dsdr_pkg::opcode_t op, int pg, int col,
                                              int val, int top, int height);
    dsdr_pkg::cmd_t c;
    c.opcode      = op;
    c.page        = pg[2:0];
    c.column      = col[6:0];
    c.pixel_byte  = val[7:0];
    c.top_row     = top[5:0];
    c.area_height = height[6:0];
    return c;
  endfunction

  function automatic dsdr_pkg::cmd_t random_cmd();
    dsdr_pkg::cmd_t c;
    int             pick;
    c.page        = 3'($urandom_range(0, 7));
    c.column      = 7'($urandom_range(0, 127));
    c.pixel_byte  = 8'($urandom_range(0, 255));
    c.top_row     = 6'($urandom_range(0, 63));
    c.area_height = 7'($urandom_range(0, 64));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      c.opcode = dsdr_pkg::OP_WRITE;
      // rewrite of the same value now and then, so it must not show as a change
      if ($urandom_range(0, 9) == 0) c.pixel_byte = tracker.pixels[c.page][c.column];
    end else if (pick < 75) begin
      c.opcode = dsdr_pkg::OP_FULL;
    end else if (pick < 95) begin
      c.opcode = dsdr_pkg::OP_AREA;
    end else begin
      c.opcode = dsdr_pkg::OP_CLEAR;
    end
    return c;
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic issue(dsdr_pkg::cmd_t c, int idle_pct);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd   = c;
    do @(posedge clk); while (busy);
    tracker.take_command(c);
    @(negedge clk);
  endtask

  task automatic write_period(logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    tracker.force_period = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    int waited = 0;
    start = 1'b0;
    while (tracker.due_segments.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] periods [RAND_PHASES] = '{8'd255, 8'd1, 8'd0, 8'd50, 8'd7};
    int         idles   [RAND_PHASES] = '{0, 73, 17, 73, 0};
    tracker     = new();
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    cycle_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_period(8'd3);
    // every display byte is written before any refresh reads it
    for (int p = 0; p < NPAGES; p++)
      for (int c = 0; c < NCOLS; c++)
        issue(make_cmd(dsdr_pkg::OP_WRITE, p, c, $urandom_range(0, 255), 0, 0), 0);

    // directed: all pages differ, no difference, forced resend after a single-byte write
    issue(make_cmd(dsdr_pkg::OP_FULL, 0, 0, 0, 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_FULL, 7, 127, 255, 63, 64), 0);
    issue(make_cmd(dsdr_pkg::OP_WRITE, 3, 5, ~tracker.pixels[3][5], 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_FULL, 0, 0, 0, 0, 0), 0);
    // page-wide span from both edge columns, then single-page area at the bottom row
    issue(make_cmd(dsdr_pkg::OP_WRITE, 0, 0, ~tracker.pixels[0][0], 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_WRITE, 0, 127, ~tracker.pixels[0][127], 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_WRITE, 7, 127, ~tracker.pixels[7][127], 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_AREA, 0, 0, 0, 0, 8), 0);
    issue(make_cmd(dsdr_pkg::OP_AREA, 0, 0, 0, 63, 1), 0);
    // wrapped range refreshes nothing
    issue(make_cmd(dsdr_pkg::OP_WRITE, 5, 64, ~tracker.pixels[5][64], 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_AREA, 0, 0, 0, 40, 64), 0);
    // zero height from row 0 spans every page
    issue(make_cmd(dsdr_pkg::OP_WRITE, 3, 5, ~tracker.pixels[3][5], 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_AREA, 0, 0, 0, 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_WRITE, 2, 9, tracker.pixels[2][9], 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_FULL, 0, 0, 0, 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_AREA, 0, 0, 0, 0, 64), 0);
    issue(make_cmd(dsdr_pkg::OP_AREA, 0, 0, 0, 63, 64), 0);
    issue(make_cmd(dsdr_pkg::OP_WRITE, 6, 64, 8'h00, 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_FULL, 0, 0, 0, 0, 0), 0);
    issue(make_cmd(dsdr_pkg::OP_FULL, 0, 0, 0, 0, 0), 0);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_period(periods[ph]);
      for (int i = 0; i < 80; i++) issue(random_cmd(), idles[ph]);
      settle();
    end

    foreach (tracker.due_segments[i])
      tracker.report_mismatch($sformatf("segment for page %0d never arrived",
                                        tracker.due_segments[i].seg_page));
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
